// ===== rtl/direct_mapped_writeback_cache_unit_assert.svh =====
// assertion macros used by the cache unit checker
`ifndef DIRECT_MAPPED_WRITEBACK_CACHE_UNIT_ASSERT_SVH
`define DIRECT_MAPPED_WRITEBACK_CACHE_UNIT_ASSERT_SVH

// clocked assertion, switched off while reset is high
`define DMWBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked assertion that also holds through reset
`define DMWBC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/dmwbc_pkg.sv =====
// shared types and constants for the direct-mapped write-back cache unit
package dmwbc_pkg;

  localparam int ADDR_W         = 10;
  localparam int DATA_W         = 8;
  localparam int MODE_W         = 2;
  localparam int DEF_NUM_LINES  = 8;
  localparam int DEF_LINE_BYTES = 8;
  localparam int DEF_MEM_BYTES  = 1024;

  typedef enum logic [MODE_W-1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_FLUSH = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_CLEAR   = 3'd1,
    OP_CAPTURE = 3'd2,
    OP_LOOKUP  = 3'd3,
    OP_WB      = 3'd4,
    OP_FILL    = 3'd5,
    OP_ACCESS  = 3'd6,
    OP_NEXT    = 3'd7
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  hit;
    logic  victim_dirty;
    logic  step_last;
    logic  clear_last;
    logic  flush_last;
  } status_t;

endpackage

// ===== rtl/dmwbc_ctrl.sv =====
// controller state machine of the cache unit
module dmwbc_ctrl
  import dmwbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MODE_W-1:0] mode,
  input  status_t           status,
  output cmd_t              cmd,
  output logic              busy,
  output logic              done
);

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_LOOKUP = 8'b0000_0100,
    ST_WBACK  = 8'b0000_1000,
    ST_FILL   = 8'b0001_0000,
    ST_ACCESS = 8'b0010_0000,
    ST_RESP   = 8'b0100_0000,
    ST_FLUSH  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;
  mode_t  mode_in;

  assign mode_in = mode_t'(mode);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and command decode
  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      ST_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE, ST_RESP: begin
        state_next = ST_IDLE;
        if (start) begin
          cmd.op = OP_CAPTURE;
          priority if (mode_in == MODE_READ || mode_in == MODE_WRITE) begin
            state_next = ST_LOOKUP;
          end else if (mode_in == MODE_FLUSH) begin
            state_next = ST_FLUSH;
          end else begin
            state_next = ST_ACCESS;
          end
        end
      end
      ST_LOOKUP: begin
        cmd.op = OP_LOOKUP;
        priority if (status.hit) begin
          state_next = ST_ACCESS;
        end else if (status.victim_dirty) begin
          state_next = ST_WBACK;
        end else begin
          state_next = ST_FILL;
        end
      end
      ST_WBACK: begin
        cmd.op = OP_WB;
        if (status.step_last) begin
          state_next = (status.mode == MODE_FLUSH) ? ST_FLUSH : ST_FILL;
        end
      end
      ST_FILL: begin
        cmd.op = OP_FILL;
        if (status.step_last) begin
          state_next = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        cmd.op     = OP_ACCESS;
        state_next = ST_RESP;
      end
      ST_FLUSH: begin
        priority if (status.victim_dirty) begin
          state_next = ST_WBACK;
        end else if (status.flush_last) begin
          state_next = ST_RESP;
        end else begin
          cmd.op = OP_NEXT;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  assign busy = !(state == ST_IDLE || state == ST_RESP);
  assign done = (state == ST_RESP);

endmodule

// ===== rtl/dmwbc_datapath.sv =====
// datapath of the cache unit: line metadata, line store, backing memory
module dmwbc_datapath
  import dmwbc_pkg::*;
#(
  parameter int NUM_LINES  = DEF_NUM_LINES,
  parameter int LINE_BYTES = DEF_LINE_BYTES,
  parameter int MEM_BYTES  = DEF_MEM_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  input  logic [MODE_W-1:0] mode,
  input  logic [ADDR_W-1:0] address,
  input  logic [DATA_W-1:0] write_data,
  output status_t           status,
  output logic [DATA_W-1:0] read_data,
  output logic              hit,
  output logic              wrote_back
);

  localparam int OFF_W = $clog2(LINE_BYTES);
  localparam int IDX_W = $clog2(NUM_LINES);
  localparam int MA_W  = $clog2(MEM_BYTES);
  localparam int LA_W  = IDX_W + OFF_W;
  localparam int TAG_W = MA_W - LA_W;
  localparam int AX_W  = (MA_W > ADDR_W) ? MA_W : ADDR_W;
  localparam int CNT_W = OFF_W + 1;

  // item registers
  mode_t             mode_r;
  logic [TAG_W-1:0]  tag_r;
  logic [OFF_W-1:0]  off_r;
  logic [DATA_W-1:0] wdata_r;
  logic [IDX_W-1:0]  cur_line;
  logic              hit_r;
  logic              wb_r;

  // counters
  logic [CNT_W-1:0]  cnt;
  logic [OFF_W-1:0]  cnt_prev;
  logic [MA_W-1:0]   clr_cnt;

  // line metadata
  logic              line_valid [NUM_LINES];
  logic              line_dirty [NUM_LINES];
  logic [TAG_W-1:0]  line_tag   [NUM_LINES];

  // memories
  logic [DATA_W-1:0] line_mem [NUM_LINES*LINE_BYTES];
  logic [DATA_W-1:0] back_mem [MEM_BYTES];
  logic [DATA_W-1:0] line_rdata;
  logic [DATA_W-1:0] mem_rdata;

  logic              line_we;
  logic              line_re;
  logic [LA_W-1:0]   line_wa;
  logic [LA_W-1:0]   line_ra;
  logic [DATA_W-1:0] line_wd;
  logic              mem_we;
  logic              mem_re;
  logic [MA_W-1:0]   mem_wa;
  logic [MA_W-1:0]   mem_ra;
  logic [DATA_W-1:0] mem_wd;

  logic [AX_W-1:0]   addr_ext;
  logic [MA_W-1:0]   addr_mem;
  logic              step_last;

  // address split, taken modulo the memory size
  assign addr_ext  = AX_W'(address);
  assign addr_mem  = addr_ext[MA_W-1:0];
  assign step_last = (cnt == CNT_W'(LINE_BYTES));
  assign cnt_prev  = cnt[OFF_W-1:0] - 1'b1;

  // item capture and per-item flags
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_r   <= MODE_NONE;
      cur_line <= '0;
      hit_r    <= 1'b0;
      wb_r     <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_CAPTURE: begin
          mode_r   <= mode_t'(mode);
          cur_line <= (mode_t'(mode) == MODE_FLUSH) ? '0 : addr_mem[LA_W-1:OFF_W];
          hit_r    <= 1'b0;
          wb_r     <= 1'b0;
        end
        OP_LOOKUP: begin
          hit_r <= status.hit;
        end
        OP_WB: begin
          if (step_last) begin
            wb_r <= 1'b1;
          end
        end
        OP_NEXT: begin
          cur_line <= cur_line + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // payload of the item
  always_ff @(posedge clk) begin
    if (cmd.op == OP_CAPTURE) begin
      tag_r   <= addr_mem[MA_W-1:LA_W];
      off_r   <= addr_mem[OFF_W-1:0];
      wdata_r <= write_data;
    end
  end

  // byte step counter for write-back and refill, clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      clr_cnt <= '0;
    end else begin
      if (cmd.op == OP_WB || cmd.op == OP_FILL) begin
        cnt <= step_last ? '0 : cnt + 1'b1;
      end
      if (cmd.op == OP_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // line metadata updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LINES; i++) begin
        line_valid[i] <= 1'b0;
        line_dirty[i] <= 1'b0;
        line_tag[i]   <= '0;
      end
    end else begin
      if (cmd.op == OP_FILL && step_last) begin
        line_tag[cur_line]   <= tag_r;
        line_valid[cur_line] <= 1'b1;
        line_dirty[cur_line] <= 1'b0;
      end
      if (cmd.op == OP_WB && step_last) begin
        line_dirty[cur_line] <= 1'b0;
      end
      if (cmd.op == OP_ACCESS && mode_r == MODE_WRITE) begin
        line_dirty[cur_line] <= 1'b1;
      end
    end
  end

  // line store port control: read one byte ahead, write one byte behind
  always_comb begin
    line_we = 1'b0;
    line_wa = {cur_line, off_r};
    line_wd = wdata_r;
    line_re = 1'b0;
    line_ra = {cur_line, off_r};
    if (cmd.op == OP_WB && !step_last) begin
      line_re = 1'b1;
      line_ra = {cur_line, cnt[OFF_W-1:0]};
    end
    if (cmd.op == OP_FILL && cnt != '0) begin
      line_we = 1'b1;
      line_wa = {cur_line, cnt_prev};
      line_wd = mem_rdata;
    end
    if (cmd.op == OP_ACCESS && mode_r == MODE_READ) begin
      line_re = 1'b1;
    end
    if (cmd.op == OP_ACCESS && mode_r == MODE_WRITE) begin
      line_we = 1'b1;
    end
  end

  // backing memory port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_cnt;
    mem_wd = '0;
    mem_re = (cmd.op == OP_FILL) && !step_last;
    mem_ra = {tag_r, cur_line, cnt[OFF_W-1:0]};
    if (cmd.op == OP_CLEAR) begin
      mem_we = 1'b1;
    end
    if (cmd.op == OP_WB && cnt != '0) begin
      mem_we = 1'b1;
      mem_wa = {line_tag[cur_line], cur_line, cnt_prev};
      mem_wd = line_rdata;
    end
  end

  // line store
  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[line_wa] <= line_wd;
    end
    if (line_re) begin
      line_rdata <= line_mem[line_ra];
    end
  end

  // backing memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      back_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rdata <= back_mem[mem_ra];
    end
  end

  // status to the controller
  assign status.mode         = mode_r;
  assign status.hit          = line_valid[cur_line] && (line_tag[cur_line] == tag_r);
  assign status.victim_dirty = line_valid[cur_line] && line_dirty[cur_line];
  assign status.step_last    = step_last;
  assign status.clear_last   = &clr_cnt;
  assign status.flush_last   = (cur_line == IDX_W'(NUM_LINES - 1));

  // result fields
  assign read_data  = (mode_r == MODE_READ) ? line_rdata : '0;
  assign hit        = hit_r;
  assign wrote_back = wb_r;

endmodule

// ===== rtl/direct_mapped_writeback_cache_unit.sv =====
// top level of the direct-mapped write-back cache unit
// Usage: a transaction is accepted on the rising edge where start is high and busy is
// low; mode (read, write, flush or unused), address and write_data are sampled there.
// Exactly one result follows: done is high for one cycle with read_data, hit and
// wrote_back; the receiver cannot hold it off and must take it in that cycle.
// Sequence from accept to done: a hit passes through lookup and access, an unused
// mode goes straight to access; a miss first refills the line, and before that
// writes back a dirty victim. A flush walks all NUM_LINES lines and writes back
// each dirty one. Refill and write-back move a line one byte at a time through the
// byte-wide memories. The next transaction may be accepted in the cycle done is
// shown; busy stays high from accept until then, so transactions never overlap.
// Reset: rst is synchronous; afterwards a clearing pass zeroes the backing memory one
// byte a cycle, with busy high; all lines start invalid and clean.
module direct_mapped_writeback_cache_unit
  import dmwbc_pkg::*;
#(
  parameter int NUM_LINES  = DEF_NUM_LINES,
  parameter int LINE_BYTES = DEF_LINE_BYTES,
  parameter int MEM_BYTES  = DEF_MEM_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [MODE_W-1:0] mode,
  input  logic [ADDR_W-1:0] address,
  input  logic [DATA_W-1:0] write_data,
  output logic              done,
  output logic [DATA_W-1:0] read_data,
  output logic              hit,
  output logic              wrote_back
);

  cmd_t    cmd;
  status_t status;

  // controller
  dmwbc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (mode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // datapath
  dmwbc_datapath #(
    .NUM_LINES  (NUM_LINES),
    .LINE_BYTES (LINE_BYTES),
    .MEM_BYTES  (MEM_BYTES)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .mode       (mode),
    .address    (address),
    .write_data (write_data),
    .status     (status),
    .read_data  (read_data),
    .hit        (hit),
    .wrote_back (wrote_back)
  );

endmodule

// ===== rtl/dmwbc_chk.sv =====
// port-level assertion checker for the cache unit, with its bind
`include "direct_mapped_writeback_cache_unit_assert.svh"

module dmwbc_chk
  import dmwbc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic              hit,
  input logic              wrote_back
);

  // a reset always leads into the clearing pass
  `DMWBC_ASSERT_RST(a_reset_busy, rst |=> busy, "not busy after reset")

  // an accepted transaction keeps the unit busy in the next cycle
  `DMWBC_ASSERT(a_accept_busy, start && !busy |=> busy, "accepted transaction not busy")

  // results never come in adjacent cycles
  `DMWBC_ASSERT(a_done_single, done |=> !done, "result strobe held for two cycles")

  // a hit never evicts a dirty line
  `DMWBC_ASSERT(a_hit_no_wb, done && hit |-> !wrote_back, "write-back reported on a hit")

endmodule

bind direct_mapped_writeback_cache_unit dmwbc_chk u_dmwbc_chk (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .hit        (hit),
  .wrote_back (wrote_back)
);

// ===== tb/sv/tb.sv =====
// self-checking testbench for the direct-mapped write-back cache unit
module tb;
  import dmwbc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_LINES    = DEF_NUM_LINES;
  localparam int LINE_BYTES   = DEF_LINE_BYTES;
  localparam int MEM_BYTES    = DEF_MEM_BYTES;
  localparam int SPAN_BYTES   = NUM_LINES * LINE_BYTES;
  localparam int NUM_TAGS     = MEM_BYTES / SPAN_BYTES;
  localparam int RANDOM_ITEMS = 1800;
  // clearing pass after reset is the longest quiet stretch, then a flush of all dirty lines
  localparam int STALL_LIMIT  = 4 * (MEM_BYTES + 2 + NUM_LINES * (LINE_BYTES + 3) + 64);
  localparam int DRAIN_CYCLES = 4 * (2 + NUM_LINES * (LINE_BYTES + 2));

  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    logic              hit;
    logic              wb;
  } cache_result_t;

  typedef struct {
    mode_t             mode;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
    int                gap;
    bit                hold;
  } cache_txn_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [MODE_W-1:0] mode = MODE_READ;
  logic [ADDR_W-1:0] address = '0;
  logic [DATA_W-1:0] write_data = '0;
  logic              busy;
  logic              done;
  logic [DATA_W-1:0] read_data;
  logic              hit;
  logic              wrote_back;

  direct_mapped_writeback_cache_unit #(
    .NUM_LINES  (NUM_LINES),
    .LINE_BYTES (LINE_BYTES),
    .MEM_BYTES  (MEM_BYTES)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .address    (address),
    .write_data (write_data),
    .done       (done),
    .read_data  (read_data),
    .hit        (hit),
    .wrote_back (wrote_back)
  );

  // shadow copy of the cache and its backing memory
  bit                shadow_valid [NUM_LINES];
  bit                shadow_dirty [NUM_LINES];
  int                shadow_tag   [NUM_LINES];
  logic [DATA_W-1:0] shadow_line  [SPAN_BYTES];
  logic [DATA_W-1:0] shadow_mem   [MEM_BYTES];

  cache_txn_t    txn_q[$];
  cache_result_t result_q[$];
  cache_txn_t    cur_txn;
  cache_txn_t    staged_txn;
  bit            staged = 1'b0;
  bit            burst_run = 1'b0;
  int            in_flight = 0;
  int            stall_cycles = 0;
  int            n_errors = 0;
  int            n_results = 0;
  int            n_mode [4];
  int            n_hits = 0;
  int            n_wbacks = 0;

  always #5 clk = ~clk;

  // copy one dirty line out to the shadow memory
  function automatic void spill_line(int idx);
    int base;
    int i;
    base = ((shadow_tag[idx] * NUM_LINES + idx) * LINE_BYTES) % MEM_BYTES;
    for (i = 0; i < LINE_BYTES; i++)
      shadow_mem[(base + i) % MEM_BYTES] = shadow_line[idx * LINE_BYTES + i];
    shadow_dirty[idx] = 1'b0;
  endfunction

  // bring a line in, returns {hit, wrote back}
  function automatic logic [1:0] bring_in(int idx, int tag);
    int base;
    int i;
    logic wb;
    wb = 1'b0;
    if (shadow_valid[idx] && shadow_tag[idx] == tag)
      return 2'b10;
    if (shadow_valid[idx] && shadow_dirty[idx]) begin
      spill_line(idx);
      wb = 1'b1;
    end
    base = ((tag * NUM_LINES + idx) * LINE_BYTES) % MEM_BYTES;
    for (i = 0; i < LINE_BYTES; i++)
      shadow_line[idx * LINE_BYTES + i] = shadow_mem[(base + i) % MEM_BYTES];
    shadow_tag[idx]   = tag;
    shadow_valid[idx] = 1'b1;
    shadow_dirty[idx] = 1'b0;
    return {1'b0, wb};
  endfunction

  // expected result of one transaction, updating the shadow state
  function automatic cache_result_t cache_access(cache_txn_t t);
    cache_result_t r;
    logic [1:0] hw;
    int a;
    int off;
    int idx;
    int tag;
    int i;
    r   = '0;
    a   = int'(t.addr) % MEM_BYTES;
    off = a % LINE_BYTES;
    idx = (a / LINE_BYTES) % NUM_LINES;
    tag = a / SPAN_BYTES;
    case (t.mode)
      MODE_READ: begin
        hw      = bring_in(idx, tag);
        r.hit   = hw[1];
        r.wb    = hw[0];
        r.rdata = shadow_line[idx * LINE_BYTES + off];
      end
      MODE_WRITE: begin
        hw    = bring_in(idx, tag);
        r.hit = hw[1];
        r.wb  = hw[0];
        shadow_line[idx * LINE_BYTES + off] = t.wdata;
        shadow_dirty[idx] = 1'b1;
      end
      MODE_FLUSH: begin
        for (i = 0; i < NUM_LINES; i++) begin
          if (shadow_valid[i] && shadow_dirty[i]) begin
            spill_line(i);
            r.wb = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // mostly back to back, some short pauses, a few long ones
  function automatic int pick_gap(bit no_idle);
    int r;
    if (no_idle)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic queue_txn(mode_t m, int a, int d, bit hold);
    cache_txn_t t;
    t.mode  = m;
    t.addr  = a[ADDR_W-1:0];
    t.wdata = d[DATA_W-1:0];
    t.gap   = pick_gap(burst_run);
    t.hold  = hold;
    txn_q.push_back(t);
  endtask

  task automatic report_mismatch(string field, int want, int got);
    n_errors++;
    $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, got);
  endtask

  // driver: presents queued transactions and predicts each one on acceptance
  always @(posedge clk) begin
    logic took;
    logic nxt_start;
    cache_result_t res;
    if (rst) begin
      start <= 1'b0;
    end else begin
      took      = start && !busy;
      nxt_start = start && !took;
      if (took) begin
        res = cache_access(cur_txn);
        result_q.push_back(res);
        in_flight++;
        n_mode[cur_txn.mode]++;
        n_hits   += res.hit;
        n_wbacks += res.wb;
      end
      if (done)
        in_flight--;
      if (!nxt_start) begin
        if (!staged && txn_q.size() != 0) begin
          staged_txn = txn_q.pop_front();
          staged     = 1'b1;
        end
        if (staged) begin
          if (staged_txn.gap > 0) begin
            staged_txn.gap--;
          end else if (!staged_txn.hold || in_flight == 0) begin
            cur_txn    = staged_txn;
            staged     = 1'b0;
            mode       <= cur_txn.mode;
            address    <= cur_txn.addr;
            write_data <= cur_txn.wdata;
            nxt_start  = 1'b1;
          end
        end
      end
      start <= nxt_start;
    end
  end

  // monitor: each result against the oldest prediction
  always @(posedge clk) begin
    cache_result_t want;
    if (!rst && done) begin
      n_results++;
      if (result_q.size() == 0) begin
        n_errors++;
        $display("%0t: result with no transaction outstanding: read_data %0h hit %0b wb %0b",
                 $time, read_data, hit, wrote_back);
      end else begin
        want = result_q.pop_front();
        if (read_data !== want.rdata) report_mismatch("read_data", want.rdata, read_data);
        if (hit !== want.hit) report_mismatch("hit", want.hit, hit);
        if (wrote_back !== want.wb) report_mismatch("wrote_back", want.wb, wrote_back);
      end
    end
  end

  // watchdog on cycles with neither an accepted transaction nor a result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("tb: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int issued;
    int k;
    int r;
    int hot_tag;
    int a;
    mode_t m;

    for (k = 0; k < NUM_LINES; k++) begin
      shadow_valid[k] = 1'b0;
      shadow_dirty[k] = 1'b0;
      shadow_tag[k]   = 0;
    end
    for (k = 0; k < MEM_BYTES; k++)
      shadow_mem[k] = '0;
    for (k = 0; k < 4; k++)
      n_mode[k] = 0;

    // directed: empty flush, hits and misses on both ends of memory, dirty evictions
    queue_txn(MODE_FLUSH, 0, 0, 1'b0);
    queue_txn(MODE_READ, 'h000, 0, 1'b0);
    queue_txn(MODE_WRITE, 'h000, 'hff, 1'b0);
    queue_txn(MODE_READ, 'h000, 0, 1'b0);
    queue_txn(MODE_WRITE, 'h3ff, 'ha5, 1'b0);
    queue_txn(MODE_READ, 'h3ff, 0, 1'b0);
    queue_txn(MODE_READ, 'h040, 0, 1'b0);
    queue_txn(MODE_READ, 'h000, 0, 1'b0);
    queue_txn(MODE_WRITE, 'h005, 'h00, 1'b0);
    queue_txn(MODE_WRITE, 'h23a, 'h5a, 1'b0);
    queue_txn(MODE_READ, 'h3ff, 0, 1'b0);
    queue_txn(MODE_FLUSH, 'h3ff, 'hff, 1'b0);
    queue_txn(MODE_FLUSH, 0, 0, 1'b0);
    queue_txn(MODE_NONE, 'h3ff, 'hff, 1'b0);
    queue_txn(MODE_NONE, 'h000, 'h00, 1'b1);
    queue_txn(MODE_WRITE, 'h1c4, 'h3c, 1'b0);
    queue_txn(MODE_READ, 'h1c4, 0, 1'b0);
    queue_txn(MODE_WRITE, 'h2aa, 'hc3, 1'b0);
    queue_txn(MODE_FLUSH, 0, 0, 1'b1);
    queue_txn(MODE_READ, 'h2aa, 0, 1'b0);
    queue_txn(MODE_READ, 'h004, 0, 1'b0);
    queue_txn(MODE_READ, 'h1c4, 0, 1'b0);

    // random: mostly a small working set of tags so hits and conflict evictions are common
    issued  = 0;
    k       = 0;
    hot_tag = 0;
    while (issued < RANDOM_ITEMS) begin
      if (k % 50 == 0) begin
        burst_run = ($urandom_range(0, 3) == 0);
        hot_tag   = $urandom_range(0, NUM_TAGS - 3);
      end
      r = $urandom_range(0, 99);
      if (r < 44)      m = MODE_READ;
      else if (r < 84) m = MODE_WRITE;
      else if (r < 89) m = MODE_FLUSH;
      else             m = MODE_NONE;
      if ($urandom_range(0, 3) == 0)
        a = $urandom_range(0, (1 << ADDR_W) - 1);
      else
        a = ((hot_tag + $urandom_range(0, 2)) * SPAN_BYTES
             + $urandom_range(0, SPAN_BYTES - 1)) % MEM_BYTES;
      queue_txn(m, a, $urandom_range(0, 255), $urandom_range(0, 199) == 0);
      issued++;
      k++;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // wait for the stimulus to run out, then for the last results
    @(negedge clk);
    while (txn_q.size() != 0 || staged || start)
      @(negedge clk);
    while (result_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("run: %0d reads, %0d writes, %0d flushes, %0d unused-mode transactions",
             n_mode[MODE_READ], n_mode[MODE_WRITE], n_mode[MODE_FLUSH], n_mode[MODE_NONE]);
    $display("run: %0d results checked, %0d hits, %0d with write-back, %0d errors",
             n_results, n_hits, n_wbacks, n_errors);
    if (n_errors == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
